@@ src/plcd_pkg.sv @@
// Shared types and constants for the pinned LRU cache directory.
// Item payload structs, op and status codes, cell commands and flags.
// No dependencies.
package plcd_pkg;

  localparam int TAG_BITS     = 32;
  localparam int VER_BITS     = 32;
  localparam int ENTRIES_DEF  = 16;
  localparam int PIN_BITS_DEF = 8;
  localparam int CAP_BITS     = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic [2:0] ADDR_CAP = 3'd0;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_RELEASE = 3'd1,
    OP_CANCEL = 3'd2,
    OP_MARK = 3'd3,
    OP_UNLINK = 3'd4,
    OP_DRAIN = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_Q_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]          op;
    logic [TAG_BITS-1:0] key_tag;
    logic [3:0]          slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [3:0]          result_slot;
    logic                hit;
    logic                evict_marked;
    logic [VER_BITS-1:0] version;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_HIT,
    CMD_FREE,
    CMD_INSERT,
    CMD_DEC,
    CMD_MARK,
    CMD_PEND
  } cell_cmd_e;

  typedef struct packed {
    logic valid;
    logic match;
    logic dirty;
    logic pend;
    logic pin_zero;
    logic pin_one;
  } cell_flags_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_INSERT,
    FSM_DRAIN
  } fsm_e;

endpackage

@@ src/plcd_cell.sv @@
// One directory entry: tag, pin count, marks, version and recency rank.
// Acts on the command broadcast along the row. Depends on plcd_pkg.
module plcd_cell #(
  parameter int IW       = 4,
  parameter int PIN_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plcd_pkg::cell_cmd_e           cmd,
  input  logic                          sel,
  input  logic [plcd_pkg::TAG_BITS-1:0] tag_in,
  input  logic [plcd_pkg::TAG_BITS-1:0] probe_tag,
  input  logic [IW-1:0]                 rank_ref,
  output plcd_pkg::cell_flags_t         flags,
  output logic [IW-1:0]                 rank,
  output logic [plcd_pkg::VER_BITS-1:0] version
);
  import plcd_pkg::*;

  logic                valid;
  logic                dirty;
  logic                pend;
  logic [PIN_BITS-1:0] pin;
  logic [TAG_BITS-1:0] tag;

  assign flags.valid    = valid;
  assign flags.match    = valid && (tag == probe_tag);
  assign flags.dirty    = dirty;
  assign flags.pend     = pend;
  assign flags.pin_zero = (pin == '0);
  assign flags.pin_one  = (pin == PIN_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      pend  <= 1'b0;
      pin   <= '0;
    end else begin
      unique case (cmd)
        CMD_HIT: begin
          if (sel) begin
            if (pin != '1) pin <= pin + PIN_BITS'(1);
          end
        end
        CMD_FREE: begin
          if (sel) begin
            valid <= 1'b0;
            pin   <= '0;
            dirty <= 1'b0;
            pend  <= 1'b0;
          end
        end
        CMD_INSERT: begin
          if (sel) begin
            valid <= 1'b1;
            pin   <= PIN_BITS'(1);
            dirty <= 1'b0;
            pend  <= 1'b0;
          end
        end
        CMD_DEC: begin
          if (sel && pin != '0) pin <= pin - PIN_BITS'(1);
        end
        CMD_MARK: begin
          if (sel) dirty <= 1'b1;
        end
        CMD_PEND: begin
          if (sel) pend <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_HIT: begin
        if (sel) rank <= '0;
        else if (valid && rank < rank_ref) rank <= rank + IW'(1);
      end
      CMD_FREE: begin
        if (!sel && valid && rank > rank_ref) rank <= rank - IW'(1);
      end
      CMD_INSERT: begin
        if (sel) begin
          rank    <= '0;
          tag     <= tag_in;
          version <= VER_BITS'(1);
        end else if (valid) begin
          rank <= rank + IW'(1);
        end
      end
      CMD_MARK: begin
        if (sel) version <= version + VER_BITS'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/plcd_qcell.sv @@
// One dirty queue place. Removal shifts later places down one step along
// the chain; the match carry runs from head to tail. Depends on nothing.
module plcd_qcell #(
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          live,
  input  logic          push,
  input  logic [IW-1:0] push_val,
  input  logic          remove,
  input  logic [IW-1:0] key,
  input  logic [IW-1:0] shift_in,
  input  logic          hit_in,
  output logic          hit_out,
  output logic [IW-1:0] val
);

  assign hit_out = hit_in || (live && val == key);

  always_ff @(posedge clk) begin
    if (remove && hit_out) val <= shift_in;
    else if (push) val <= push_val;
  end

endmodule

@@ src/pinned_lru_cache_directory.sv @@
// Pinned LRU cache directory.
// Input channel in_valid/in_ready/in_item carries one op per item; output
// channel out_valid/out_ready/out_item carries results, last marking the
// final result of an item. Capacity limit is set through the APB port at
// address 0 (reset value 16); the user must write it only while idle,
// the block does not enforce this. Ops run one at a time; a missing
// lookup passes through the exec and insert states before its result,
// a drain gives one result per queued slot, one per cycle while the
// receiver does not stall, and a new item is accepted only in idle. The
// entry row does all tag compares, rank updates and victim selection in
// parallel per cell; the dirty queue shifts later places down on removal.
// Results sit in a single output register; while the receiver stalls, the
// next item is still accepted, and its result waits until the register is
// freed. Reset clears all entries, the dirty queue and occupancy, and sets
// the capacity limit to 16. The block is usable on the cycle after reset.
// Depends on plcd_pkg, plcd_cell, plcd_qcell.
module pinned_lru_cache_directory #(
  parameter int ENTRIES  = plcd_pkg::ENTRIES_DEF,
  parameter int PIN_BITS = plcd_pkg::PIN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  plcd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output plcd_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import plcd_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = IW + 4;

  fsm_e state, state_next;
  in_item_t cur;
  logic [CAP_BITS-1:0] cap;
  logic [CW-1:0] occ, qlen;
  logic [IW-1:0] cnt;
  logic em;

  cell_flags_t flags [ENTRIES];
  logic [IW-1:0] ranks [ENTRIES];
  logic [VER_BITS-1:0] vers [ENTRIES];
  logic [IW-1:0] qval [ENTRIES];
  logic [ENTRIES:0] qhit;

  cell_cmd_e cmd;
  logic [IW-1:0] cmd_idx, rank_ref;
  logic q_push, q_remove, occ_inc, occ_dec, len_clear, emit, em_set;
  logic [IW-1:0] q_key;
  out_item_t emit_item;

  logic hit_any, vic_any, free_any, ofree;
  logic [IW-1:0] hidx, vidx, fidx, sidx;
  logic [XW-1:0] sx;
  logic [CW-1:0] occm1;
  logic slot_ok, evict_try;
  logic is_lookup, is_drain, is_known;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAP) ? 32'(cap) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) cap <= CAP_RESET;
    else if (psel && penable && pwrite && paddr == ADDR_CAP) cap <= pwdata[CAP_BITS-1:0];
  end

  // entry row
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    plcd_cell #(.IW(IW), .PIN_BITS(PIN_BITS)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .sel(cmd_idx == IW'(g)),
      .tag_in(cur.key_tag), .probe_tag(cur.key_tag), .rank_ref(rank_ref),
      .flags(flags[g]), .rank(ranks[g]), .version(vers[g])
    );
  end

  // dirty queue chain
  assign qhit[0] = 1'b0;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_q
    plcd_qcell #(.IW(IW)) u_q (
      .clk(clk), .live(CW'(g) < qlen), .push(q_push && qlen == CW'(g)),
      .push_val(q_key), .remove(q_remove), .key(q_key),
      .shift_in((g == ENTRIES - 1) ? qval[g] : qval[(g + 1) % ENTRIES]),
      .hit_in(qhit[g]), .hit_out(qhit[g+1]), .val(qval[g])
    );
  end

  assign occm1 = occ - CW'(1);
  assign sx    = XW'(cur.slot_index);
  assign sidx  = sx[IW-1:0];
  assign slot_ok = (32'(cur.slot_index) < ENTRIES) && flags[sidx].valid;

  always_comb begin
    hit_any = 1'b0; vic_any = 1'b0; free_any = 1'b0;
    hidx = '0; vidx = '0; fidx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (flags[i].match) begin
        hit_any = 1'b1; hidx = IW'(i);
      end
      if (flags[i].valid && occ != '0 && CW'(ranks[i]) == occm1) begin
        vic_any = 1'b1; vidx = IW'(i);
      end
      if (!flags[i].valid) begin
        free_any = 1'b1; fidx = IW'(i);
      end
    end
  end

  assign evict_try = (32'(occ) >= 32'(cap)) && vic_any && !flags[vidx].pend
                     && flags[vidx].pin_zero;
  assign ofree     = !out_valid || out_ready;
  assign is_lookup = (cur.op == OP_LOOKUP);
  assign is_drain  = (cur.op == OP_DRAIN);
  assign is_known  = (cur.op <= OP_DRAIN);

  function automatic logic [3:0] slot4(input logic [IW-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[3:0];
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (in_valid) state_next = FSM_EXEC;
      FSM_EXEC: begin
        if (is_lookup && !hit_any) state_next = FSM_INSERT;
        else if (is_drain && qlen != '0) state_next = FSM_DRAIN;
        else if (ofree) state_next = FSM_IDLE;
      end
      FSM_INSERT: if (ofree) state_next = FSM_IDLE;
      FSM_DRAIN: if (ofree && CW'(cnt) + CW'(1) == qlen) state_next = FSM_IDLE;
      default: state_next = FSM_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd = CMD_NONE; cmd_idx = sidx; rank_ref = '0;
    q_push = 1'b0; q_remove = 1'b0; q_key = sidx;
    occ_inc = 1'b0; occ_dec = 1'b0; len_clear = 1'b0;
    emit = 1'b0; em_set = 1'b0;
    emit_item = '0;
    emit_item.last = 1'b1;
    unique case (state)
      FSM_EXEC: begin
        if (is_lookup && !hit_any) begin
          if (evict_try) begin
            cmd_idx = vidx; rank_ref = ranks[vidx];
            if (flags[vidx].dirty) begin
              cmd = CMD_PEND; em_set = 1'b1;
            end else begin
              cmd = CMD_FREE; q_remove = 1'b1; q_key = vidx; occ_dec = 1'b1;
            end
          end
        end else if (is_drain && qlen != '0) begin
        end else if (ofree) begin
          emit = 1'b1;
          if (is_lookup) begin
            cmd = CMD_HIT; cmd_idx = hidx; rank_ref = ranks[hidx];
            emit_item.result_slot = slot4(hidx);
            emit_item.hit = 1'b1;
            emit_item.version = vers[hidx];
          end else if (is_drain) begin
            emit_item.status = ST_Q_EMPTY;
          end else if (!is_known) begin
          end else if (!slot_ok) begin
            emit_item.status = ST_BAD_SLOT;
          end else begin
            emit_item.result_slot = slot4(sidx);
            unique case (cur.op)
              OP_RELEASE: cmd = CMD_DEC;
              OP_CANCEL: begin
                if (flags[sidx].pin_one) begin
                  cmd = CMD_FREE; rank_ref = ranks[sidx];
                  q_remove = 1'b1; occ_dec = 1'b1;
                end else begin
                  cmd = CMD_DEC;
                end
              end
              OP_MARK: begin
                cmd = CMD_MARK;
                q_push = !flags[sidx].dirty && 32'(qlen) < ENTRIES;
                emit_item.version = vers[sidx] + VER_BITS'(1);
              end
              default: q_remove = 1'b1;
            endcase
          end
        end
      end
      FSM_INSERT: begin
        if (ofree) begin
          emit = 1'b1;
          emit_item.evict_marked = em;
          if (free_any) begin
            cmd = CMD_INSERT; cmd_idx = fidx; occ_inc = 1'b1;
            emit_item.result_slot = slot4(fidx);
            emit_item.version = VER_BITS'(1);
          end else begin
            emit_item.status = ST_NO_SLOT;
          end
        end
      end
      FSM_DRAIN: begin
        if (ofree) begin
          emit = 1'b1;
          emit_item.result_slot = slot4(qval[cnt]);
          emit_item.last = (CW'(cnt) + CW'(1) == qlen);
          len_clear = emit_item.last;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == FSM_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cur <= in_item;
    if (emit) out_item <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      occ       <= '0;
      qlen      <= '0;
      cnt       <= '0;
      em        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (occ_inc) occ <= occ + CW'(1);
      else if (occ_dec && occ != '0) occ <= occ - CW'(1);
      if (len_clear) qlen <= '0;
      else if (q_push) qlen <= qlen + CW'(1);
      else if (q_remove && qhit[ENTRIES]) qlen <= qlen - CW'(1);
      if (state == FSM_EXEC) cnt <= '0;
      else if (state == FSM_DRAIN && ofree) cnt <= cnt + IW'(1);
      if (state == FSM_IDLE) em <= 1'b0;
      else if (em_set) em <= 1'b1;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
